[rtl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, opcode codes and beat structures of the circle rasteriser.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = 11;
	localparam int PT_BITS     = 14;
	localparam int OFS_BITS    = RADIUS_BITS + 2;
	localparam int ERR_BITS    = 2 * RADIUS_BITS + 6;
	localparam int GRP_PTS     = 8;
	localparam int IDX_BITS    = $clog2(GRP_PTS);

	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [COORD_BITS-1:0]   center_x;
		logic [COORD_BITS-1:0]   center_y;
		logic [RADIUS_BITS-1:0]  radius;
	} cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]        center_x;
		logic [COORD_BITS-1:0]        center_y;
		logic signed [OFS_BITS-1:0]   ofs_x;
		logic signed [OFS_BITS-1:0]   ofs_y;
		logic                         done;
	} grp_t;

endpackage

[rtl/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle outline generator, eight symmetric points per advance.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid / cmd_stall): opcode start loads centre and
// radius and gives no point; opcode advance gives eight points of the current
// octet set, or nothing when no circle is running.
// Point channel (pt_valid / pt_stall): one point per beat; last_of_group marks
// the eighth point of an advance, circle_done the eighth point of the final one.
// Path: an accepted command is held in the command register, an advance then
// moves into the octet register, and its points leave through the point output
// register. The single point port drains the octet register, and a new command
// is taken while the previous octet is still draining.
// Reset clears all control and circle state; no circle runs afterwards.
// When the receiver stalls, the point stays put, the octet register fills,
// and cmd_stall rises once a registered advance cannot move on.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  mcr_pkg::opcode_t                      opcode,
	input  logic [mcr_pkg::COORD_BITS-1:0]        center_x,
	input  logic [mcr_pkg::COORD_BITS-1:0]        center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
	output logic                                  pt_valid,
	input  logic                                  pt_stall,
	output logic signed [mcr_pkg::PT_BITS-1:0]    point_x,
	output logic signed [mcr_pkg::PT_BITS-1:0]    point_y,
	output logic                                  last_of_group,
	output logic                                  circle_done
);
	import mcr_pkg::*;

	cmd_t                       cmd_s1;
	logic                       valid_s1;
	logic                       cmd_accept;
	logic                       s1_take;
	logic                       drawing;
	grp_t                       grp;

	grp_t                       grp_q;
	logic                       grp_valid_q;
	logic [IDX_BITS-1:0]        idx_q;
	logic                       grp_load;
	logic                       grp_free;
	logic                       idx_last;
	logic                       emit;
	logic                       pt_ready;

	logic                       pt_valid_q;
	logic signed [PT_BITS-1:0]  px_q;
	logic signed [PT_BITS-1:0]  py_q;
	logic                       last_q;
	logic                       done_q;

	logic signed [PT_BITS-1:0]  cx_e;
	logic signed [PT_BITS-1:0]  cy_e;
	logic signed [PT_BITS-1:0]  x_e;
	logic signed [PT_BITS-1:0]  y_e;
	logic signed [PT_BITS-1:0]  sel_x;
	logic signed [PT_BITS-1:0]  sel_y;

	assign pt_ready   = ~pt_valid_q | ~pt_stall;
	assign idx_last   = idx_q == IDX_BITS'(GRP_PTS - 1);
	assign emit       = grp_valid_q & pt_ready;
	assign grp_free   = ~grp_valid_q | (pt_ready & idx_last);
	assign s1_take    = valid_s1 & ((cmd_s1.opcode == OP_START) | ~drawing | grp_free);
	assign grp_load   = s1_take & (cmd_s1.opcode == OP_ADVANCE) & drawing;
	assign cmd_stall  = valid_s1 & ~s1_take;
	assign cmd_accept = cmd_valid & ~cmd_stall;

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			cmd_s1.opcode   <= opcode;
			cmd_s1.center_x <= center_x;
			cmd_s1.center_y <= center_y;
			cmd_s1.radius   <= radius;
		end
	end

	mcr_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_s1),
		.cmd_fire (s1_take),
		.drawing  (drawing),
		.grp      (grp)
	);

	// octet register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (grp_load) begin
			grp_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (emit) begin
			if (idx_last) begin
				grp_valid_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_q <= grp;
		end
	end

	always_comb begin
		cx_e = PT_BITS'(grp_q.center_x);
		cy_e = PT_BITS'(grp_q.center_y);
		x_e  = PT_BITS'(grp_q.ofs_x);
		y_e  = PT_BITS'(grp_q.ofs_y);
		case (idx_q)
			3'd0: begin sel_x = cx_e + x_e; sel_y = cy_e + y_e; end
			3'd1: begin sel_x = cx_e + x_e; sel_y = cy_e - y_e; end
			3'd2: begin sel_x = cx_e - x_e; sel_y = cy_e + y_e; end
			3'd3: begin sel_x = cx_e - x_e; sel_y = cy_e - y_e; end
			3'd4: begin sel_x = cx_e + y_e; sel_y = cy_e + x_e; end
			3'd5: begin sel_x = cx_e + y_e; sel_y = cy_e - x_e; end
			3'd6: begin sel_x = cx_e - y_e; sel_y = cy_e + x_e; end
			3'd7: begin sel_x = cx_e - y_e; sel_y = cy_e - x_e; end
			default: begin sel_x = cx_e; sel_y = cy_e; end
		endcase
	end

	// point output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_q <= 1'b0;
		end else if (pt_ready) begin
			pt_valid_q <= grp_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			px_q   <= sel_x;
			py_q   <= sel_y;
			last_q <= idx_last;
			done_q <= idx_last & grp_q.done;
		end
	end

	assign pt_valid      = pt_valid_q;
	assign point_x       = px_q;
	assign point_y       = py_q;
	assign last_of_group = last_q;
	assign circle_done   = done_q;

endmodule

[rtl/mcr_tracker.sv]
// ----------------------------------------------------------------------------
// mcr_tracker
// Holds the running circle: centre, offsets and the midpoint error term.
// ----------------------------------------------------------------------------
module mcr_tracker (
	input  logic          clk,
	input  logic          arst_n,
	input  mcr_pkg::cmd_t cmd,
	input  logic          cmd_fire,
	output logic          drawing,
	output mcr_pkg::grp_t grp
);
	import mcr_pkg::*;

	logic [COORD_BITS-1:0]      cx_q;
	logic [COORD_BITS-1:0]      cy_q;
	logic signed [OFS_BITS-1:0] x_q;
	logic signed [OFS_BITS-1:0] y_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic                       drawing_q;

	logic signed [OFS_BITS-1:0] x_next;
	logic signed [OFS_BITS-1:0] y_next;
	logic signed [ERR_BITS-1:0] err_step;
	logic signed [ERR_BITS-1:0] err_dec;
	logic signed [ERR_BITS-1:0] err_next;
	logic signed [ERR_BITS-1:0] err_init;
	logic                       dec;
	logic                       done;

	// err = (2x-1)^2 + 4(y+1)^2 - 4r^2, kept by differences
	always_comb begin
		dec      = ~err_q[ERR_BITS-1];
		y_next   = y_q + OFS_BITS'(1);
		x_next   = dec ? x_q - OFS_BITS'(1) : x_q;
		done     = x_next < y_next;
		err_step = err_q + (ERR_BITS'(y_q) <<< 3) + ERR_BITS'(12);
		err_dec  = (ERR_BITS'(1) - ERR_BITS'(x_q)) <<< 3;
		err_next = dec ? err_step + err_dec : err_step;
		err_init = ERR_BITS'(5) - (ERR_BITS'(cmd.radius) << 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q      <= '0;
			cy_q      <= '0;
			x_q       <= '0;
			y_q       <= '0;
			err_q     <= '0;
			drawing_q <= 1'b0;
		end else if (cmd_fire) begin
			if (cmd.opcode == OP_START) begin
				cx_q      <= cmd.center_x;
				cy_q      <= cmd.center_y;
				x_q       <= OFS_BITS'(cmd.radius);
				y_q       <= '0;
				err_q     <= err_init;
				drawing_q <= 1'b1;
			end else if (drawing_q) begin
				x_q       <= x_next;
				y_q       <= y_next;
				err_q     <= err_next;
				drawing_q <= ~done;
			end
		end
	end

	assign drawing      = drawing_q;
	assign grp.center_x = cx_q;
	assign grp.center_y = cy_q;
	assign grp.ofs_x    = x_q;
	assign grp.ofs_y    = y_q;
	assign grp.done     = done;

endmodule

[rtl/mcr_checker.sv]
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks of the circle rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	input  logic                                  cmd_stall,
	input  mcr_pkg::opcode_t                      opcode,
	input  logic [mcr_pkg::COORD_BITS-1:0]        center_x,
	input  logic [mcr_pkg::COORD_BITS-1:0]        center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
	input  logic                                  pt_valid,
	input  logic                                  pt_stall,
	input  logic signed [mcr_pkg::PT_BITS-1:0]    point_x,
	input  logic signed [mcr_pkg::PT_BITS-1:0]    point_y,
	input  logic                                  last_of_group,
	input  logic                                  circle_done
);
	import mcr_pkg::*;

	logic                       pt_beat;
	logic [IDX_BITS-1:0]        beat_cnt_q;
	logic signed [PT_BITS-1:0]  prev_x_q;

	assign pt_beat = pt_valid & ~pt_stall;

	// beat position inside the current octet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_cnt_q <= '0;
		end else if (pt_beat) begin
			beat_cnt_q <= beat_cnt_q + IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pt_beat) begin
			prev_x_q <= point_x;
		end
	end

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(opcode) && $stable(center_x)
			&& $stable(center_y) && $stable(radius))
		else $error("stalled command beat changed");

	a_pt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_stall |=> pt_valid && $stable(point_x) && $stable(point_y)
			&& $stable(last_of_group) && $stable(circle_done))
		else $error("stalled point beat changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && circle_done |-> last_of_group)
		else $error("circle_done without last_of_group");

	a_group_len: assert property (@(posedge clk) disable iff (!arst_n)
		pt_beat |-> (last_of_group == (beat_cnt_q == IDX_BITS'(GRP_PTS - 1))))
		else $error("last_of_group not on every eighth beat");

	a_pair_x: assert property (@(posedge clk) disable iff (!arst_n)
		pt_beat && beat_cnt_q == IDX_BITS'(1) |-> point_x == prev_x_q)
		else $error("second point of octet moved in x");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);

[tb/sv/circle_point_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_point_check
// Watches the command and point channels of the circle rasteriser, works out the
// eight outline points of each accepted advance of a running circle from its own
// copy of the circle state and compares each point beat with the oldest one still owed.
// ----------------------------------------------------------------------------
module circle_point_check
	import mcr_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  logic                          cmd_stall,
	input  opcode_t                       opcode,
	input  logic [COORD_BITS-1:0]         center_x,
	input  logic [COORD_BITS-1:0]         center_y,
	input  logic [RADIUS_BITS-1:0]        radius,
	input  logic                          pt_valid,
	input  logic                          pt_stall,
	input  logic signed [PT_BITS-1:0]     point_x,
	input  logic signed [PT_BITS-1:0]     point_y,
	input  logic                          last_of_group,
	input  logic                          circle_done,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		logic signed [PT_BITS-1:0] px;
		logic signed [PT_BITS-1:0] py;
		logic                      last;
		logic                      done;
	} outline_point_t;

	outline_point_t owed_points[$];

	int                     ofs_x;
	int                     ofs_y;
	logic [COORD_BITS-1:0]  ctr_x;
	logic [COORD_BITS-1:0]  ctr_y;
	logic [RADIUS_BITS-1:0] rad;
	logic                   drawing;

	initial begin
		errors  = 0;
		pending = 0;
		ofs_x   = 0;
		ofs_y   = 0;
		ctr_x   = '0;
		ctr_y   = '0;
		rad     = '0;
		drawing = 1'b0;
	end

	function automatic outline_point_t make_point(longint px, longint py, logic last,
			logic done);
		outline_point_t p;
		p.px   = px[PT_BITS-1:0];
		p.py   = py[PT_BITS-1:0];
		p.last = last;
		p.done = done;
		return p;
	endfunction

	task automatic plot_octet();
		longint cx, cy, x, y, r, mid;
		logic   fin;
		cx  = longint'(ctr_x);
		cy  = longint'(ctr_y);
		x   = longint'(ofs_x);
		y   = longint'(ofs_y);
		r   = longint'(rad);
		mid = 2 * x - 1;
		ofs_y = ofs_y + 1;
		// half-pixel midpoint test, scaled by two
		if (mid * mid + 4 * (y + 1) * (y + 1) >= 4 * r * r)
			ofs_x = ofs_x - 1;
		fin = ofs_x < ofs_y;
		if (fin)
			drawing = 1'b0;
		owed_points.push_back(make_point(cx + x, cy + y, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx + x, cy - y, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx - x, cy + y, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx - x, cy - y, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx + y, cy + x, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx + y, cy - x, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx - y, cy + x, 1'b0, 1'b0));
		owed_points.push_back(make_point(cx - y, cy - x, 1'b1, fin));
	endtask

	always @(posedge clk) begin
		outline_point_t seen, want;
		if (arst_n) begin
			if (pt_valid && !pt_stall) begin
				seen.px   = point_x;
				seen.py   = point_y;
				seen.last = last_of_group;
				seen.done = circle_done;
				if (owed_points.size() == 0) begin
					errors++;
					$display("%0t: point beat with nothing owed: (%0d, %0d) last %b done %b",
						$time, $signed(seen.px), $signed(seen.py), seen.last, seen.done);
				end else begin
					want = owed_points.pop_front();
					if (seen.px !== want.px || seen.py !== want.py ||
							seen.last !== want.last || seen.done !== want.done) begin
						errors++;
						$display("%0t: point mismatch, expected (%0d, %0d) last %b done %b,",
							$time, $signed(want.px), $signed(want.py), want.last,
							want.done, " got (%0d, %0d) last %b done %b",
							$signed(seen.px), $signed(seen.py), seen.last, seen.done);
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				if (opcode == OP_START) begin
					ctr_x   = center_x;
					ctr_y   = center_y;
					rad     = radius;
					ofs_x   = int'(radius);
					ofs_y   = 0;
					drawing = 1'b1;
				end else if (drawing) begin
					plot_octet();
				end
			end
			pending = owed_points.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start and advance commands into the circle rasteriser, first a short
// directed run over the field extremes and special cases, then random circles,
// with random command gaps and point stalls; the point checker judges beats.
// ----------------------------------------------------------------------------
module testbench;
	import mcr_pkg::*;

	logic                         clk;
	logic                         arst_n;
	logic                         cmd_valid;
	logic                         cmd_stall;
	opcode_t                      opcode;
	logic [COORD_BITS-1:0]        center_x;
	logic [COORD_BITS-1:0]        center_y;
	logic [RADIUS_BITS-1:0]       radius;
	logic                         pt_valid;
	logic                         pt_stall;
	logic signed [PT_BITS-1:0]    point_x;
	logic signed [PT_BITS-1:0]    point_y;
	logic                         last_of_group;
	logic                         circle_done;

	int   errors;
	int   pending;
	int   cmds_sent;
	logic quiet;

	midpoint_circle_rasterizer uut (.*);

	circle_point_check point_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.opcode        (opcode),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.pt_valid      (pt_valid),
		.pt_stall      (pt_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.last_of_group (last_of_group),
		.circle_done   (circle_done),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	// receiver stalls
	initial begin
		pt_stall = 1'b0;
		forever begin
			@(negedge clk);
			pt_stall <= !quiet && ($urandom_range(99) < 14);
		end
	end

	task automatic issue(opcode_t op, int cx, int cy, int r);
		while (!quiet && $urandom_range(99) < 14) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		opcode    <= op;
		center_x  <= COORD_BITS'(cx);
		center_y  <= COORD_BITS'(cy);
		radius    <= RADIUS_BITS'(r);
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
		cmds_sent++;
	endtask

	// advances carry random, unused fields
	task automatic advance(int n);
		repeat (n)
			issue(OP_ADVANCE, $urandom_range(4095), $urandom_range(4095),
				$urandom_range(2047));
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int   kind;
		int   r;
		logic paused;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		opcode    = OP_START;
		center_x  = '0;
		center_y  = '0;
		radius    = '0;
		quiet     = 1'b0;
		cmds_sent = 0;
		paused    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		advance(1);
		issue(OP_START, 0, 0, 0);
		advance(2);
		issue(OP_START, 4095, 4095, 2047);
		advance(3);
		issue(OP_START, 0, 4095, 2047);
		advance(2);
		issue(OP_START, 4095, 0, 1);
		advance(2);
		issue(OP_START, 2048, 2048, 5);
		advance(6);
		cmd_valid <= 1'b0;
		drain();

		// random circles
		while (cmds_sent < 300) begin
			quiet = (cmds_sent >= 120 && cmds_sent < 200);
			if (!paused && cmds_sent >= 60) begin
				cmd_valid <= 1'b0;
				drain();
				@(negedge clk);
				paused = 1'b1;
			end
			kind = $urandom_range(99);
			if (kind < 70) begin
				r = $urandom_range(24);
				issue(OP_START, $urandom_range(4095), $urandom_range(4095), r);
				advance(r * 3 / 4 + 2);
			end else if (kind < 80) begin
				issue(OP_START, $urandom_range(4095), $urandom_range(4095),
					$urandom_range(2047));
				advance($urandom_range(1, 6));
			end else if (kind < 90) begin
				r = $urandom_range(40);
				issue(OP_START, $urandom_range(4095), $urandom_range(4095), r);
				advance($urandom_range(r / 2));
			end else begin
				issue(opcode_t'($urandom_range(1)), $urandom_range(4095),
					$urandom_range(4095), $urandom_range(2047));
			end
		end
		quiet = 1'b0;
		cmd_valid <= 1'b0;
		drain();
		repeat (20) @(negedge clk);

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
